### rtl/pctd_pkg.sv
// package with payload types and constants for the trial-division prime counter
`timescale 1ns / 1ps

package pctd_pkg;

    localparam int VALUE_BITS = 16;
    localparam int COUNT_BITS = 32;
    // divisor width: holds the first divisor whose square passes the value
    localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS = 2 * DIV_BITS;
    localparam int BIT_CNT_BITS = $clog2(VALUE_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [DIV_BITS-1:0] FIRST_DIVISOR = DIV_BITS'(2);
    localparam logic [SQ_BITS-1:0] FIRST_SQUARE = SQ_BITS'(4);
    localparam logic [BIT_CNT_BITS-1:0] LAST_BIT = BIT_CNT_BITS'(VALUE_BITS - 1);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic batch_last;
    } item_t;

    typedef struct packed {
        logic is_prime;
        logic [COUNT_BITS-1:0] prime_total;
        logic total_last;
    } result_t;

endpackage

### rtl/prime_count_trial_division_core.sv
// top level of the trial-division prime counter
//
// usage:
//   item channel (item_valid/item_ready/item) takes one unsigned value and a
//   batch_last flag per transfer. result channel (result_valid/result_ready/
//   result) gives one transfer per item: is_prime, the saturating count of
//   primes in the batch including this item, and total_last.
//   the count returns to zero after an item with batch_last set.
//   one value is tested at a time. each trial divisor takes a check step
//   (S_CHECK) plus a bit-serial remainder over the VALUE_BITS dividend bits,
//   one dividend bit a cycle, in S_DIV. up to 254 divisors are tried for
//   16-bit values. values below 4 finish without a trial division.
//   the result sits in an output register; a new item is taken while it waits.
//   if the receiver stalls, a second finished result holds the engine until
//   the output register frees up.
//   reset clears the count, the engine and the output valid.
`timescale 1ns / 1ps

module prime_count_trial_division_core
    import pctd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [VALUE_BITS-1:0]   value_reg, value_next;
    logic                    last_reg, last_next;
    logic [VALUE_BITS-1:0]   sh_reg, sh_next;
    logic [DIV_BITS-1:0]     rem_reg, rem_next;
    logic [DIV_BITS-1:0]     div_reg, div_next;
    logic [SQ_BITS-1:0]      sq_reg, sq_next;
    logic [BIT_CNT_BITS-1:0] bit_reg, bit_next;
    logic                    prime_reg, prime_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    result_valid_reg, result_valid_next;
    result_t                 result_reg, result_next;

    logic [DIV_BITS:0]     rem_shift;
    logic [DIV_BITS:0]     rem_diff;
    logic                  rem_fit;
    logic [DIV_BITS-1:0]   rem_new;
    logic [COUNT_BITS-1:0] total;
    logic                  slot_free;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign slot_free    = !result_valid_reg || result_ready;

    // one restoring-division step per cycle
    assign rem_shift = {rem_reg, sh_reg[VALUE_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign rem_fit   = (rem_shift >= {1'b0, div_reg});
    assign rem_new   = rem_fit ? rem_diff[DIV_BITS-1:0] : rem_shift[DIV_BITS-1:0];

    assign total = (prime_reg && (count_reg != COUNT_MAX)) ? count_reg + COUNT_BITS'(1)
                                                           : count_reg;

    always_comb
    begin
        state_next        = state_reg;
        value_next        = value_reg;
        last_next         = last_reg;
        sh_next           = sh_reg;
        rem_next          = rem_reg;
        div_next          = div_reg;
        sq_next           = sq_reg;
        bit_next          = bit_reg;
        prime_next        = prime_reg;
        count_next        = count_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    value_next = item.value;
                    last_next  = item.batch_last;
                    div_next   = FIRST_DIVISOR;
                    sq_next    = FIRST_SQUARE;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (value_reg[VALUE_BITS-1:1] == '0)
                begin
                    prime_next = 1'b0;
                    state_next = S_DONE;
                end
                else if (sq_reg > SQ_BITS'(value_reg))
                begin
                    prime_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    sh_next    = value_reg;
                    rem_next   = '0;
                    bit_next   = LAST_BIT;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = rem_new;
                sh_next  = {sh_reg[VALUE_BITS-2:0], 1'b0};
                bit_next = bit_reg - BIT_CNT_BITS'(1);
                if (bit_reg == '0)
                begin
                    if (rem_new == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next    = sq_reg + SQ_BITS'({div_reg, 1'b1});
                        div_next   = div_reg + DIV_BITS'(1);
                        state_next = S_CHECK;
                    end
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    result_next.is_prime    = prime_reg;
                    result_next.prime_total = total;
                    result_next.total_last  = last_reg;
                    result_valid_next       = 1'b1;
                    count_next              = last_reg ? '0 : total;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        last_reg   <= last_next;
        sh_reg     <= sh_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        sq_reg     <= sq_next;
        bit_reg    <= bit_next;
        prime_reg  <= prime_next;
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    a_div_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_reg >= FIRST_DIVISOR))
        else $error("divisor below first divisor");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < div_reg))
        else $error("partial remainder not below divisor");

    a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && slot_free && last_reg) |=> (count_reg == '0))
        else $error("count not cleared after batch end");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && slot_free && !last_reg && !prime_reg)
        |=> (count_reg == $past(count_reg)))
        else $error("count changed on a non-prime");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && slot_free) |=> (result_valid_reg && state_reg == S_IDLE))
        else $error("finished result not loaded");
`endif

endmodule

### tb/tb_top.sv
// testbench for the trial-division prime counter: scoreboard, drivers and end-of-run checks
`timescale 1ns / 1ps

module tb_top;

    import pctd_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 108;
    localparam int DRAIN_CYCLES   = 20;

    class prime_scoreboard;
        result_t                 expected_q[$];
        logic [COUNT_BITS-1:0]   batch_primes;
        int                      errors;

        function new();
            batch_primes = '0;
            errors = 0;
        endfunction

        function bit trial_prime(logic [VALUE_BITS-1:0] v);
            int unsigned d;
            if (v < 2)
                return 1'b0;
            for (d = 2; d * d <= v; d++)
                if (v % d == 0)
                    return 1'b0;
            return 1'b1;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_item(item_t it);
            result_t exp_r;
            exp_r.is_prime = trial_prime(it.value);
            if (exp_r.is_prime && batch_primes != COUNT_MAX)
                batch_primes++;
            exp_r.prime_total = batch_primes;
            exp_r.total_last = it.batch_last;
            if (it.batch_last)
                batch_primes = '0;
            expected_q.push_back(exp_r);
        endfunction

        task check_result(result_t got);
            result_t exp_r;
            if (expected_q.size() == 0) begin
                report("result transfer with nothing expected");
            end
            else begin
                exp_r = expected_q.pop_front();
                if (got.is_prime !== exp_r.is_prime)
                    report($sformatf("is_prime got %b expected %b",
                                     got.is_prime, exp_r.is_prime));
                if (got.prime_total !== exp_r.prime_total)
                    report($sformatf("prime_total got %0d expected %0d",
                                     got.prime_total, exp_r.prime_total));
                if (got.total_last !== exp_r.total_last)
                    report($sformatf("total_last got %b expected %b",
                                     got.total_last, exp_r.total_last));
            end
        endtask
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    prime_scoreboard sb;
    bit hold_req;
    bit no_idle;
    int idle_cycles;

    prime_count_trial_division_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 120);
        return $urandom_range(1, 4);
    endfunction

    function logic [VALUE_BITS-1:0] pick_value();
        int unsigned d;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VALUE_BITS'($urandom_range(0, 65535));
            4, 5:       return VALUE_BITS'($urandom_range(0, 300));
            6:          return VALUE_BITS'(65535 - $urandom_range(0, 40));
            7:
            begin
                d = $urandom_range(2, 255);
                return VALUE_BITS'(d * d);
            end
            default:    return VALUE_BITS'($urandom_range(0, 15));
        endcase
    endfunction

    task send_item(input logic [VALUE_BITS-1:0] v, input logic last);
        item_t it;
        it.value = v;
        it.batch_last = last;
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    task sender_gap();
        if (!no_idle && $urandom_range(0, 2) == 0)
        begin
            item_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    task sender_pause();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // transfer monitors sample pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
            sb.note_item(item);
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("** prime_count_trial_division_core: FAILED **");
            $finish;
        end
    end

    // receiver
    initial
    begin
        result_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (no_idle || $urandom_range(0, 2) != 0)
            begin
                result_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
        end
    end

    // sender and end of run
    initial
    begin
        sb = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        hold_req = 1'b0;
        no_idle = 1'b0;
        idle_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small values, square boundaries, extremes and bit patterns
        send_item(16'd0, 1'b0);     sender_gap();
        send_item(16'd1, 1'b0);     sender_gap();
        send_item(16'd2, 1'b0);     sender_gap();
        send_item(16'd3, 1'b0);     sender_gap();
        send_item(16'd4, 1'b0);     sender_gap();
        send_item(16'd5, 1'b0);     sender_gap();
        send_item(16'd9, 1'b0);     sender_gap();
        send_item(16'd25, 1'b0);    sender_gap();
        send_item(16'd49, 1'b1);    sender_gap();
        send_item(16'd2, 1'b1);     sender_gap();
        send_item(16'd251, 1'b0);   sender_gap();
        send_item(16'd257, 1'b0);   sender_gap();
        send_item(16'd65025, 1'b0); sender_gap();
        send_item(16'd65521, 1'b0); sender_gap();
        send_item(16'd65535, 1'b0); sender_gap();
        send_item(16'd65534, 1'b0); sender_gap();
        send_item(16'h8000, 1'b0);  sender_gap();
        send_item(16'hAAAA, 1'b0);  sender_gap();
        send_item(16'h5555, 1'b0);  sender_gap();
        send_item(16'd32749, 1'b1);
        sender_pause();

        // long receiver hold while fast items back up
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(VALUE_BITS'($urandom_range(0, 3)), 1'($urandom_range(0, 3) == 0));
        sender_pause();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 60 && i < 90);
            send_item(pick_value(), 1'($urandom_range(0, 7) == 0));
            sender_gap();
        end
        send_item(pick_value(), 1'b1);
        item_valid <= 1'b0;
        no_idle = 1'b0;

        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("** prime_count_trial_division_core: PASSED **");
        else
            $display("** prime_count_trial_division_core: FAILED **");
        $finish;
    end

endmodule
